>>> rtl/core/gas_pkg.sv
// Shared types, codes and slot helpers for the gantry autosquare sequencer.
package gas_pkg;

  localparam int PAIR_COUNT = 3;
  localparam int SLOTS      = 6;
  localparam int PAIRS_MAX  = SLOTS / 2;

  // Motor status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_SQUARED = 2'd1;
  localparam logic [1:0] ST_FINISH  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PAIR_ACTIVE    = 2'd0;
  localparam logic [1:0] CFG_PAIR_REVERSE   = 2'd1;
  localparam logic [1:0] CFG_ENDSTOP_INVERT = 2'd2;
  localparam logic [1:0] CFG_HOLD_TICKS     = 2'd3;

  typedef struct packed {
    logic [5:0]  run_forward;
    logic [5:0]  force_stop;
    logic [5:0]  start_back;
    logic [5:0]  dir_level;
    logic        dir_takeover;
    logic [11:0] motor_status;
    logic [1:0]  run_phase;
  } result_t;

  // Slots of pairs that exist and are enabled
  function automatic logic [5:0] active_slots(input logic [2:0] pair_active);
    logic [5:0] m;
    m = '0;
    for (int p = 0; p < PAIRS_MAX; p++) begin
      if (p < PAIR_COUNT && pair_active[p]) begin
        m[2*p]   = 1'b1;
        m[2*p+1] = 1'b1;
      end
    end
    return m;
  endfunction

  // Direction levels of active slots, forward or back
  function automatic logic [5:0] dir_levels(input logic [2:0] pair_active,
                                            input logic [2:0] pair_reverse,
                                            input logic       fwd);
    logic [5:0] m;
    logic       lvl;
    m = '0;
    for (int p = 0; p < PAIRS_MAX; p++) begin
      lvl = fwd ? ~pair_reverse[p] : pair_reverse[p];
      if (p < PAIR_COUNT && pair_active[p] && lvl) begin
        m[2*p]   = 1'b1;
        m[2*p+1] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/core/gantry_autosquare_sequencer_core.sv
// Gantry autosquare sequencer: poll-tick state machine with a two-entry output stage.
//
// Usage: one input transfer per poll tick carries the button levels, the raw
// endstop bits and the motor-running flags. Each input transfer produces
// exactly one result transfer with the step pulses (run_forward, force_stop,
// start_back), the direction lines, the takeover flag, the per-motor status
// and the run phase after that tick.
// Result: registered in the output register, or in the skid register while the output stalls.
// Throughput: one item per cycle while the skid register is empty; all per-motor checks are six parallel
// compares between the input and the sequencer state registers.
// Stall: results go into an output register backed by a skid register, so
// one more item is taken while a result waits; in_ready drops only when both
// hold results. Results are never dropped or repeated.
// Configuration: cfg_ready is always high; write registers only while idle.
// Index 0 pair_active, 1 pair_reverse, 2 endstop_invert, 3 hold_ticks.
// Reset (rst, synchronous): phase idle, hold timer cleared, every motor
// status none, registers zero, output stage empty.
module gantry_autosquare_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        button_local,
  input  logic        button_remote,
  input  logic [5:0]  endstop_raw,
  input  logic [5:0]  motor_running,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  run_forward,
  output logic [5:0]  force_stop,
  output logic [5:0]  start_back,
  output logic [5:0]  dir_level,
  output logic        dir_takeover,
  output logic [11:0] motor_status,
  output logic [1:0]  run_phase
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEEK = 2'd1,
    PH_BACK = 2'd2,
    PH_WAIT = 2'd3
  } phase_t;

  // configuration registers
  logic [2:0]  pair_active;
  logic [2:0]  pair_reverse;
  logic [5:0]  endstop_invert;
  logic [15:0] hold_ticks;

  // sequencer state
  phase_t      phase, phase_next;
  logic        button_seen, button_seen_next;
  logic [15:0] hold_count, hold_count_next;
  logic [1:0]  motor_state [gas_pkg::SLOTS];
  logic [1:0]  motor_state_next [gas_pkg::SLOTS];

  // output stage
  gas_pkg::result_t out_q, skid_q, res;
  logic             skid_valid;

  logic        accept;
  logic        button;
  logic [5:0]  endstops;
  logic [5:0]  act;
  logic        all_done;
  logic        finish_run;
  logic [16:0] elapsed;
  logic [5:0]  fwd, stop, back;
  logic [11:0] status;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_valid;
  assign accept    = in_valid & in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_active    <= '0;
      pair_reverse   <= '0;
      endstop_invert <= '0;
      hold_ticks     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gas_pkg::CFG_PAIR_ACTIVE:    pair_active    <= cfg_data[2:0];
        gas_pkg::CFG_PAIR_REVERSE:   pair_reverse   <= cfg_data[2:0];
        gas_pkg::CFG_ENDSTOP_INVERT: endstop_invert <= cfg_data[5:0];
        gas_pkg::CFG_HOLD_TICKS:     hold_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Compute next state and the result of this tick
  always_comb begin
    button           = button_local | button_remote;
    endstops         = endstop_raw ^ endstop_invert;
    act              = gas_pkg::active_slots(pair_active);
    phase_next       = phase;
    button_seen_next = button_seen;
    hold_count_next  = hold_count;
    motor_state_next = motor_state;
    fwd              = '0;
    stop             = '0;
    back             = '0;
    finish_run       = 1'b0;
    all_done         = 1'b1;
    elapsed          = {1'b0, hold_count} + 17'd1;
    status           = '0;

    case (phase)
      PH_IDLE: begin
        if (!button) begin
          button_seen_next = 1'b0;
        end else if (!button_seen) begin
          button_seen_next = 1'b1;
          hold_count_next  = '0;
        end else if (elapsed > {1'b0, hold_ticks}) begin
          for (int s = 0; s < gas_pkg::SLOTS; s++) begin
            motor_state_next[s] = gas_pkg::ST_NONE;
          end
          fwd        = act;
          phase_next = PH_SEEK;
        end else begin
          hold_count_next = elapsed[15:0];
        end
      end
      PH_SEEK: begin
        if (!button) begin
          finish_run = 1'b1;
        end else begin
          // stop each motor on its own endstop
          for (int s = 0; s < gas_pkg::SLOTS; s++) begin
            if (act[s] && motor_state[s] != gas_pkg::ST_SQUARED) begin
              if (endstops[s]) begin
                motor_state_next[s] = gas_pkg::ST_SQUARED;
                stop[s]             = 1'b1;
              end else begin
                all_done = 1'b0;
              end
            end
          end
          if (all_done) begin
            back       = act;
            phase_next = PH_BACK;
          end
        end
      end
      PH_BACK: begin
        if (!button) begin
          finish_run = 1'b1;
        end else begin
          // finish each motor once its move has ended
          for (int s = 0; s < gas_pkg::SLOTS; s++) begin
            if (act[s] && motor_state[s] != gas_pkg::ST_FINISH) begin
              if (!motor_running[s]) begin
                motor_state_next[s] = gas_pkg::ST_FINISH;
              end else begin
                all_done = 1'b0;
              end
            end
          end
          finish_run = all_done;
        end
      end
      default: begin
        if (!button) begin
          button_seen_next = 1'b0;
          phase_next       = PH_IDLE;
        end
      end
    endcase

    // Abort or end of run: stop every active motor
    if (finish_run) begin
      stop = stop | act;
      if (button) begin
        phase_next = PH_WAIT;
      end else begin
        button_seen_next = 1'b0;
        phase_next       = PH_IDLE;
      end
    end

    for (int s = 0; s < gas_pkg::SLOTS; s++) begin
      status[2*s +: 2] = motor_state_next[s];
    end

    res.run_forward  = fwd;
    res.force_stop   = stop;
    res.start_back   = back;
    res.dir_level    = (phase_next == PH_SEEK || phase_next == PH_BACK) ?
                       gas_pkg::dir_levels(pair_active, pair_reverse,
                                           phase_next == PH_SEEK) : '0;
    res.dir_takeover = (phase_next == PH_SEEK || phase_next == PH_BACK);
    res.motor_status = status;
    res.run_phase    = phase_next;
  end

  // Advance sequencer state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      button_seen <= 1'b0;
      hold_count  <= '0;
      for (int s = 0; s < gas_pkg::SLOTS; s++) begin
        motor_state[s] <= gas_pkg::ST_NONE;
      end
    end else if (accept) begin
      phase       <= phase_next;
      button_seen <= button_seen_next;
      hold_count  <= hold_count_next;
      motor_state <= motor_state_next;
    end
  end

  // Hold results in the output register, spill to skid when stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (accept) begin
        skid_q <= res;
      end
    end else if (skid_valid) begin
      out_q <= skid_q;
    end else if (accept) begin
      out_q <= res;
    end
  end

  assign run_forward  = out_q.run_forward;
  assign force_stop   = out_q.force_stop;
  assign start_back   = out_q.start_back;
  assign dir_level    = out_q.dir_level;
  assign dir_takeover = out_q.dir_takeover;
  assign motor_status = out_q.motor_status;
  assign run_phase    = out_q.run_phase;

`ifndef SYNTH
  // skid entry only exists behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // takeover matches the reported phase
  a_takeover_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dir_takeover == (run_phase == PH_SEEK || run_phase == PH_BACK)))
    else $error("dir_takeover disagrees with run_phase");

  // direction lines are released whenever takeover is off
  a_dir_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !dir_takeover) |-> (dir_level == '0))
    else $error("direction lines driven without takeover");

  // the output register holds a valid result in the cycle after any accepted item
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");
`endif

endmodule

>>> tb/sv/gantry_autosquare_sequencer_core_test.sv
// Self-checking testbench for the gantry autosquare sequencer core.
module gantry_autosquare_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          DRAIN_LIMIT     = 1000000;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          ITEMS_PER_PHASE = 220;
  localparam int          MAX_PRINTED     = 50;
  localparam int          LONG_PRESS      = 150;
  localparam logic [15:0] HOLD_MAX        = 16'hffff;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEEK = 2'd1,
    PH_BACK = 2'd2,
    PH_WAIT = 2'd3
  } seq_phase_t;

  typedef struct packed {
    logic       btn_local;
    logic       btn_remote;
    logic [5:0] endstops;
    logic [5:0] running;
  } tick_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = gas_pkg::CFG_PAIR_ACTIVE;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        button_local = 1'b0;
  logic        button_remote = 1'b0;
  logic [5:0]  endstop_raw = '0;
  logic [5:0]  motor_running = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  run_forward;
  logic [5:0]  force_stop;
  logic [5:0]  start_back;
  logic [5:0]  dir_level;
  logic        dir_takeover;
  logic [11:0] motor_status;
  logic [1:0]  run_phase;

  // Register mirror
  logic [2:0]  cfg_active = '0;
  logic [2:0]  cfg_reverse = '0;
  logic [5:0]  cfg_invert = '0;
  logic [15:0] cfg_hold = '0;

  // Sequencer state mirror
  seq_phase_t  seq_phase = PH_IDLE;
  logic        btn_seen = 1'b0;
  logic [15:0] hold_elapsed = '0;
  logic [1:0]  motor_progress [gas_pkg::SLOTS] = '{default: gas_pkg::ST_NONE};

  // Stimulus and scoreboard
  tick_t            pending_ticks [$];
  gas_pkg::result_t expected_results [$];
  tick_t            cur_tick;
  int               ticks_queued = 0;
  int               results_seen = 0;
  int               error_count = 0;
  bit               idling_on = 1'b1;
  int               hold_requests = 0;
  int               hold_served = 0;
  int unsigned      in_gap_left = 0;
  int unsigned      out_stall_left = 0;
  int               idle_cycles = 0;

  gantry_autosquare_sequencer_core i_dut (.*);

  always #1 clk = ~clk;

  task automatic report_failure(string msg);
    if (error_count < MAX_PRINTED)
      $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [5:0] rand6();
    return 6'($urandom_range(0, 63));
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idling_on)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the sequencer mirror by one poll tick and return its result
  function automatic gas_pkg::result_t advance_sequencer(tick_t t);
    gas_pkg::result_t r;
    logic        btn;
    logic        all_done;
    logic        end_run;
    logic        lvl;
    logic [5:0]  act;
    logic [5:0]  hits;
    logic [16:0] elapsed;
    r = '0;
    act = '0;
    end_run = 1'b0;
    btn = t.btn_local | t.btn_remote;
    hits = t.endstops ^ cfg_invert;
    for (int p = 0; p < gas_pkg::PAIRS_MAX; p++) begin
      if (p < gas_pkg::PAIR_COUNT && cfg_active[p])
        act[2*p +: 2] = 2'b11;
    end

    case (seq_phase)
      PH_IDLE: begin
        if (!btn) begin
          btn_seen = 1'b0;
        end else if (!btn_seen) begin
          btn_seen = 1'b1;
          hold_elapsed = '0;
        end else begin
          elapsed = {1'b0, hold_elapsed} + 17'd1;
          if (elapsed > {1'b0, cfg_hold}) begin
            for (int s = 0; s < gas_pkg::SLOTS; s++)
              motor_progress[s] = gas_pkg::ST_NONE;
            r.run_forward = act;
            seq_phase = PH_SEEK;
          end else begin
            hold_elapsed = elapsed[15:0];
          end
        end
      end
      PH_SEEK: begin
        if (!btn) begin
          end_run = 1'b1;
        end else begin
          all_done = 1'b1;
          for (int s = 0; s < gas_pkg::SLOTS; s++) begin
            if (act[s] && motor_progress[s] != gas_pkg::ST_SQUARED) begin
              if (hits[s]) begin
                motor_progress[s] = gas_pkg::ST_SQUARED;
                r.force_stop[s] = 1'b1;
              end else begin
                all_done = 1'b0;
              end
            end
          end
          if (all_done) begin
            r.start_back = act;
            seq_phase = PH_BACK;
          end
        end
      end
      PH_BACK: begin
        if (!btn) begin
          end_run = 1'b1;
        end else begin
          all_done = 1'b1;
          for (int s = 0; s < gas_pkg::SLOTS; s++) begin
            if (act[s] && motor_progress[s] != gas_pkg::ST_FINISH) begin
              if (!t.running[s])
                motor_progress[s] = gas_pkg::ST_FINISH;
              else
                all_done = 1'b0;
            end
          end
          end_run = all_done;
        end
      end
      default: begin
        if (!btn) begin
          btn_seen = 1'b0;
          seq_phase = PH_IDLE;
        end
      end
    endcase

    // Stop everything on abort or completion
    if (end_run) begin
      r.force_stop = r.force_stop | act;
      if (btn) begin
        seq_phase = PH_WAIT;
      end else begin
        btn_seen = 1'b0;
        seq_phase = PH_IDLE;
      end
    end

    for (int p = 0; p < gas_pkg::PAIRS_MAX; p++) begin
      lvl = (seq_phase == PH_SEEK) ? ~cfg_reverse[p] : cfg_reverse[p];
      if ((seq_phase == PH_SEEK || seq_phase == PH_BACK) && act[2*p] && lvl)
        r.dir_level[2*p +: 2] = 2'b11;
    end
    r.dir_takeover = (seq_phase == PH_SEEK || seq_phase == PH_BACK);
    for (int s = 0; s < gas_pkg::SLOTS; s++)
      r.motor_status[2*s +: 2] = motor_progress[s];
    r.run_phase = seq_phase;
    return r;
  endfunction

  task automatic compare_field(string name, logic [11:0] got, logic [11:0] want);
    if (got !== want)
      report_failure($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                               results_seen, name, got, want));
  endtask

  task automatic check_result();
    gas_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report_failure("result transfer with nothing expected");
      return;
    end
    want = expected_results.pop_front();
    compare_field("run_forward", 12'(run_forward), 12'(want.run_forward));
    compare_field("force_stop", 12'(force_stop), 12'(want.force_stop));
    compare_field("start_back", 12'(start_back), 12'(want.start_back));
    compare_field("dir_level", 12'(dir_level), 12'(want.dir_level));
    compare_field("dir_takeover", 12'(dir_takeover), 12'(want.dir_takeover));
    compare_field("motor_status", motor_status, want.motor_status);
    compare_field("run_phase", 12'(run_phase), 12'(want.run_phase));
    results_seen++;
  endtask

  function automatic void queue_tick(logic bl, logic br, logic [5:0] es, logic [5:0] mr);
    tick_t t;
    t.btn_local = bl;
    t.btn_remote = br;
    t.endstops = es;
    t.running = mr;
    pending_ticks.push_back(t);
    ticks_queued++;
  endfunction

  // Pressed tick from the local button, the remote client or both
  function automatic void queue_press(logic [5:0] es, logic [5:0] mr);
    logic [1:0] lv;
    lv = 2'($urandom_range(1, 3));
    queue_tick(lv[0], lv[1], es, mr);
  endfunction

  // One squaring run with random content, sometimes broken off
  function automatic void queue_run(int unsigned hold);
    logic [5:0] hit;
    logic [5:0] moving;
    int         abort_at;
    int         k;
    hit = '0;
    moving = 6'h3f;
    k = 0;
    abort_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 12)) : -1;
    // let go first so the hold timer starts clean
    repeat ($urandom_range(1, 2)) queue_tick(1'b0, 1'b0, rand6(), rand6());
    // short press that lets go before the hold time runs out
    if (hold < 64 && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, hold + 1)) queue_press(rand6(), rand6());
      queue_tick(1'b0, 1'b0, rand6(), rand6());
    end
    repeat (hold + 2) queue_press(rand6(), rand6());
    // endstops close a few at a time
    while (hit != 6'h3f) begin
      hit = hit | (rand6() & rand6());
      if (k == abort_at) begin
        queue_tick(1'b0, 1'b0, rand6(), rand6());
        return;
      end
      queue_press(hit ^ cfg_invert, rand6());
      k++;
    end
    // step generators wind down a few at a time
    while (moving != '0) begin
      moving = moving & (rand6() | rand6());
      if (k == abort_at) begin
        queue_tick(1'b0, 1'b0, rand6(), rand6());
        return;
      end
      queue_press(rand6(), moving);
      k++;
    end
    // linger in the release wait, then let go
    repeat ($urandom_range(0, 3)) queue_press(rand6(), rand6());
    queue_tick(1'b0, 1'b0, rand6(), rand6());
  endfunction

  // Write all four registers back to back; called right after a rising edge
  task automatic write_config(logic [2:0] act, logic [2:0] rev, logic [5:0] inv,
                              logic [15:0] hold);
    logic [1:0]  reg_order [4];
    logic [15:0] reg_value [4];
    reg_order = '{gas_pkg::CFG_PAIR_ACTIVE, gas_pkg::CFG_PAIR_REVERSE,
                  gas_pkg::CFG_ENDSTOP_INVERT, gas_pkg::CFG_HOLD_TICKS};
    reg_value = '{16'(act), 16'(rev), 16'(inv), hold};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= reg_value[i];
      do @(posedge clk); while (!cfg_ready);
      // mirror the register that just took the write
      case (cfg_index)
        gas_pkg::CFG_PAIR_ACTIVE:    cfg_active  = cfg_data[2:0];
        gas_pkg::CFG_PAIR_REVERSE:   cfg_reverse = cfg_data[2:0];
        gas_pkg::CFG_ENDSTOP_INVERT: cfg_invert  = cfg_data[5:0];
        gas_pkg::CFG_HOLD_TICKS:     cfg_hold    = cfg_data;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Sample on the falling edge, return aligned to a rising edge
  task automatic wait_drained();
    int n;
    n = 0;
    do begin
      @(negedge clk);
      n++;
    end while (!(pending_ticks.size() == 0 && !in_valid && expected_results.size() == 0)
               && n < DRAIN_LIMIT);
    @(posedge clk);
  endtask

  // Driver: present queued ticks, predict each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap_left = 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(advance_sequencer(cur_tick));
      if (!in_valid || in_ready) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          cur_tick = pending_ticks.pop_front();
          button_local  <= cur_tick.btn_local;
          button_remote <= cur_tick.btn_remote;
          endstop_raw   <= cur_tick.endstops;
          motor_running <= cur_tick.running;
          in_valid      <= 1'b1;
          in_gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, stall at random or on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall_left = 0;
    end else begin
      if (out_valid && out_ready)
        check_result();
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        out_stall_left = HOLD_OFF_CYCLES;
        out_ready <= 1'b0;
      end else if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall_left = pick_gap();
      end
    end
  end

  // Watchdog: give up after too long without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [2:0]  act;
    logic [2:0]  rev;
    logic [5:0]  inv;
    logic [15:0] hold;
    int          base;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: all pairs, pair 1 reversed, pair 2 endstops inverted, hold of one tick
    write_config(3'b111, 3'b010, 6'b110000, 16'd1);
    @(negedge clk);
    queue_tick(1'b0, 1'b0, 6'h00, 6'h00);
    // hold timing across local, remote and both
    queue_tick(1'b1, 1'b0, 6'h3f, 6'h3f);
    queue_tick(1'b0, 1'b1, 6'h3f, 6'h3f);
    queue_tick(1'b1, 1'b1, 6'h3f, 6'h3f);
    // pairs square one after another, the inverted pair last
    queue_tick(1'b1, 1'b0, 6'h33, 6'h3f);
    queue_tick(1'b1, 1'b0, 6'h3c, 6'h3f);
    queue_tick(1'b1, 1'b0, 6'h00, 6'h3f);
    // drive back, odd slots finish first, then all
    queue_tick(1'b0, 1'b1, 6'h00, 6'h3f);
    queue_tick(1'b0, 1'b1, 6'h00, 6'h15);
    queue_tick(1'b1, 1'b1, 6'h00, 6'h00);
    // release out of the wait
    queue_tick(1'b0, 1'b0, 6'h3f, 6'h3f);
    // abort while seeking
    queue_tick(1'b1, 1'b0, 6'h00, 6'h00);
    queue_tick(1'b1, 1'b0, 6'h00, 6'h00);
    queue_tick(1'b0, 1'b1, 6'h00, 6'h00);
    queue_tick(1'b0, 1'b0, 6'h00, 6'h00);
    // abort while driving back
    queue_tick(1'b1, 1'b0, 6'h00, 6'h3f);
    queue_tick(1'b1, 1'b0, 6'h00, 6'h3f);
    queue_tick(1'b1, 1'b0, 6'h00, 6'h3f);
    queue_tick(1'b1, 1'b0, 6'h0f, 6'h3f);
    queue_tick(1'b0, 1'b0, 6'h0f, 6'h3f);
    wait_drained();

    // Directed: no pair active, seeking and driving back finish at once
    write_config(3'b000, 3'b111, 6'h3f, 16'd0);
    @(negedge clk);
    queue_tick(1'b0, 1'b0, 6'h2a, 6'h15);
    queue_tick(1'b0, 1'b1, 6'h15, 6'h2a);
    queue_tick(1'b0, 1'b1, 6'h2a, 6'h15);
    queue_tick(1'b1, 1'b0, 6'h15, 6'h2a);
    queue_tick(1'b1, 1'b0, 6'h3f, 6'h3f);
    queue_tick(1'b0, 1'b0, 6'h00, 6'h00);
    wait_drained();

    // Random runs under a different setting per phase
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      act  = 3'($urandom_range(0, 7));
      rev  = 3'($urandom_range(0, 7));
      inv  = rand6();
      hold = 16'($urandom_range(0, 4));
      case (ph)
        0: begin
          act = 3'b111;
          rev = 3'b111;
          inv = 6'h3f;
          hold = '0;
        end
        1: act = 3'b000;
        2: begin
          act = 3'b111;
          rev = 3'b000;
          inv = 6'h00;
        end
        default: ;
      endcase
      write_config(act, rev, inv, hold);
      @(negedge clk);
      idling_on = (ph % 3 != 2);
      base = ticks_queued;
      while (ticks_queued - base < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 5))
            queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand6(), rand6());
        end else begin
          queue_run(cfg_hold);
        end
      end
      // hold the result side off so the block fills up and stalls its input
      if (ph == 4)
        hold_requests++;
      wait_drained();
    end

    // Longest hold time: a long press that never reaches it, back to back
    write_config(3'b111, 3'($urandom_range(0, 7)), rand6(), HOLD_MAX);
    @(negedge clk);
    idling_on = 1'b0;
    queue_tick(1'b0, 1'b0, rand6(), rand6());
    repeat (LONG_PRESS) queue_press(rand6(), rand6());
    queue_tick(1'b0, 1'b0, rand6(), rand6());
    wait_drained();

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/gas_pkg.sv
rtl/core/gantry_autosquare_sequencer_core.sv
tb/sv/gantry_autosquare_sequencer_core_test.sv
